>>> hdl/pidis_pkg.sv
// Shared types and constants for the integral-separation PID block.
`timescale 1ns / 1ps
`default_nettype none
package pidis_pkg;

	localparam int GAIN_W   = 16;
	localparam int IBOUND_W = 31;
	localparam int OBOUND_W = 23;
	localparam int THRESH_W = 23;
	localparam int INTEG_W  = 32;
	localparam int CFG_W    = 31;
	localparam int CFG_IDX_W = 3;

	localparam logic [THRESH_W-1:0] SEP_THRESH_RESET = 23'd2560;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_INTEG_BND  = 3'd3,
		REG_OUT_BND    = 3'd4,
		REG_SEP_THRESH = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [IBOUND_W-1:0]      integral_bound;
		logic [OBOUND_W-1:0]      output_bound;
		logic [THRESH_W-1:0]      separation_threshold;
	} cfg_t;

	// handshake between a producer and the queue
	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;

endpackage
`default_nettype wire

>>> hdl/pidis_front.sv
// Front end: takes error words, runs integral separation and clamping, keeps loop state.
`timescale 1ns / 1ps
`default_nettype none
module pidis_front
	import pidis_pkg::*;
#(
	parameter int ERROR_WIDTH = 24,
	localparam int ENT_W = ERROR_WIDTH + (ERROR_WIDTH + 1) + INTEG_W
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  cfg_t                         cfg,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire signed [ERROR_WIDTH-1:0] error_in,
	input  wire                          clear,
	output q_ctl_t                       q_ctl_unused_full_in_dummy,
	input  wire                          q_full,
	output logic [ENT_W-1:0]             q_data
);

	localparam int EW   = ERROR_WIDTH;
	localparam int AW   = INTEG_W + 1;
	localparam int CMPW = ((EW + 1) > THRESH_W ? (EW + 1) : THRESH_W) + 1;

	logic signed [INTEG_W-1:0] integral_q;
	logic signed [EW-1:0]      last_error_q;

	logic              accept;
	logic [EW:0]       mag;
	logic              below;
	logic signed [AW-1:0] sum_a, integ_pre, bnd_pos, bnd_neg, integ_cl;
	logic signed [EW:0]   diff;
	logic signed [EW-1:0] e_w;
	logic signed [INTEG_W-1:0] integ_w;
	logic signed [EW:0]   diff_w;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		mag = error_in[EW-1] ? -{error_in[EW-1], error_in} : {error_in[EW-1], error_in};
		below = {{(CMPW-EW-1){1'b0}}, mag} < {{(CMPW-THRESH_W){1'b0}}, cfg.separation_threshold};
		sum_a = AW'(integral_q) + AW'(error_in);
		integ_pre = below ? sum_a : '0;
		bnd_pos = $signed({{(AW-IBOUND_W){1'b0}}, cfg.integral_bound});
		bnd_neg = -bnd_pos;
		if (integ_pre > bnd_pos) begin
			integ_cl = bnd_pos;
		end else if (integ_pre < bnd_neg) begin
			integ_cl = bnd_neg;
		end else begin
			integ_cl = integ_pre;
		end
		diff = (EW + 1)'(error_in) - (EW + 1)'(last_error_q);
		// a cleared word goes down as all zeros, which gives drive 0, not saturated
		if (clear) begin
			e_w     = '0;
			integ_w = '0;
			diff_w  = '0;
		end else begin
			e_w     = error_in;
			integ_w = integ_cl[INTEG_W-1:0];
			diff_w  = diff;
		end
	end

	assign q_data = {integ_w, diff_w, e_w};
	assign q_ctl_unused_full_in_dummy.push = accept;
	assign q_ctl_unused_full_in_dummy.full = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			last_error_q <= '0;
		end else if (accept) begin
			integral_q   <= integ_w;
			last_error_q <= e_w;
		end
	end

endmodule
`default_nettype wire

>>> hdl/pidis_queue.sv
// Two-entry queue between the front end and the multiply pipeline.
`timescale 1ns / 1ps
`default_nettype none
module pidis_queue
	import pidis_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  q_ctl_t           wr_ctl,
	output logic             full,
	input  wire [WIDTH-1:0]  wr_data,
	output logic             rd_valid,
	input  wire              rd_pop,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign push     = wr_ctl.push && !wr_ctl.full;
	assign pop      = rd_pop && (count_q != 2'd0);
	assign full     = count_q[1];
	assign rd_valid = count_q != 2'd0;
	assign rd_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/pidis_back.sv
// Back end: gain products, term sum and output clamp, with an output register.
`timescale 1ns / 1ps
`default_nettype none
module pidis_back
	import pidis_pkg::*;
#(
	parameter int ERROR_WIDTH = 24,
	parameter int FRAC_BITS   = 8,
	localparam int ENT_W = ERROR_WIDTH + (ERROR_WIDTH + 1) + INTEG_W
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  cfg_t                   cfg,
	input  wire                    in_valid,
	output logic                   in_pop,
	input  wire [ENT_W-1:0]        in_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [ERROR_WIDTH-1:0] drive,
	output logic                   saturated
);

	localparam int EW = ERROR_WIDTH;
	localparam int PW = (GAIN_W + EW + 1 > GAIN_W + INTEG_W) ? (GAIN_W + EW + 1)
	                                                          : (GAIN_W + INTEG_W);
	localparam int SW = PW + 2;

	logic signed [EW-1:0]      e;
	logic signed [EW:0]        diff;
	logic signed [INTEG_W-1:0] integ;

	logic signed [GAIN_W+EW-1:0]      mp;
	logic signed [GAIN_W+EW:0]        md;
	logic signed [GAIN_W+INTEG_W-1:0] mi;

	logic                 valid_s1, valid_s2, out_valid_q;
	logic signed [PW-1:0] prod_p_s1, prod_i_s1, prod_d_s1;
	logic signed [SW-1:0] sum_s2;
	logic [EW-1:0]        drive_q;
	logic                 sat_q;

	logic ready_out, ready_s2, ready_s1;
	logic signed [SW-1:0] bnd_pos, bnd_neg, clamped;
	logic                 clip;

	assign {integ, diff, e} = in_data;

	assign mp = cfg.gain_p * e;
	assign mi = cfg.gain_i * integ;
	assign md = cfg.gain_d * diff;

	// each stage moves when the one after it is empty or moving
	assign ready_out = !out_valid_q || out_ready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_pop    = in_valid && ready_s1;

	always_comb begin
		bnd_pos = $signed({{(SW-OBOUND_W){1'b0}}, cfg.output_bound});
		bnd_neg = -bnd_pos;
		if (sum_s2 > bnd_pos) begin
			clamped = bnd_pos;
			clip    = 1'b1;
		end else if (sum_s2 < bnd_neg) begin
			clamped = bnd_neg;
			clip    = 1'b1;
		end else begin
			clamped = sum_s2;
			clip    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			prod_p_s1 <= PW'(mp);
			prod_i_s1 <= PW'(mi);
			prod_d_s1 <= PW'(md);
		end
		if (ready_s2) begin
			sum_s2 <= SW'(prod_p_s1 >>> FRAC_BITS) + SW'(prod_i_s1 >>> FRAC_BITS)
			        + SW'(prod_d_s1 >>> FRAC_BITS);
		end
		if (ready_out) begin
			drive_q <= clamped[EW-1:0];
			sat_q   <= clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_out) out_valid_q <= valid_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign saturated = sat_q;

endmodule
`default_nettype wire

>>> hdl/pid_integral_separation.sv
// Top level: config registers, front end, queue and PID back end.
// An accepted word is written to the queue, then registered as products, sum and clamped output.
// Throughput: one word per cycle while m_axis_tready holds; the integral and last-error update
// in the front end is registered on accept, and the back end is a three-register pipeline.
// Reset (arst_n low, asynchronous): state, queue and pipeline emptied, gains and bounds
// cleared, separation threshold set to 2560 (10.0 if error words carry 8 fraction bits).
`timescale 1ns / 1ps
`default_nettype none
module pid_integral_separation
	import pidis_pkg::*;
#(
	parameter int ERROR_WIDTH = 24,
	parameter int FRAC_BITS   = 8,
	localparam int TDW = ((ERROR_WIDTH + 7) / 8) * 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [CFG_W-1:0]     cfg_data,
	input  wire                 s_axis_tvalid,
	output logic                s_axis_tready,
	input  wire [TDW-1:0]       s_axis_tdata,  // error_in
	input  wire                 s_axis_tuser,  // clear
	output logic                m_axis_tvalid,
	input  wire                 m_axis_tready,
	output logic [TDW-1:0]      m_axis_tdata,  // drive
	output logic                m_axis_tuser   // saturated
);

	localparam int EW    = ERROR_WIDTH;
	localparam int ENT_W = EW + (EW + 1) + INTEG_W;

	cfg_t             cfg_q;
	q_ctl_t           q_ctl;
	logic             q_full, q_valid, q_pop;
	logic [ENT_W-1:0] q_wdata, q_rdata;
	logic [EW-1:0]    drive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p               <= '0;
			cfg_q.gain_i               <= '0;
			cfg_q.gain_d               <= '0;
			cfg_q.integral_bound       <= '0;
			cfg_q.output_bound         <= '0;
			cfg_q.separation_threshold <= SEP_THRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:     cfg_q.gain_p <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:     cfg_q.gain_i <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:     cfg_q.gain_d <= cfg_data[GAIN_W-1:0];
				REG_INTEG_BND:  cfg_q.integral_bound <= cfg_data[IBOUND_W-1:0];
				REG_OUT_BND:    cfg_q.output_bound <= cfg_data[OBOUND_W-1:0];
				REG_SEP_THRESH: cfg_q.separation_threshold <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	pidis_front #(.ERROR_WIDTH(EW)) u_front (
		.clk                       (clk),
		.arst_n                    (arst_n),
		.cfg                       (cfg_q),
		.in_valid                  (s_axis_tvalid),
		.in_ready                  (s_axis_tready),
		.error_in                  (s_axis_tdata[EW-1:0]),
		.clear                     (s_axis_tuser),
		.q_ctl_unused_full_in_dummy(q_ctl),
		.q_full                    (q_full),
		.q_data                    (q_wdata)
	);

	pidis_queue #(.WIDTH(ENT_W)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_ctl  (q_ctl),
		.full    (q_full),
		.wr_data (q_wdata),
		.rd_valid(q_valid),
		.rd_pop  (q_pop),
		.rd_data (q_rdata)
	);

	pidis_back #(.ERROR_WIDTH(EW), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (q_valid),
		.in_pop   (q_pop),
		.in_data  (q_rdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.drive    (drive),
		.saturated(m_axis_tuser)
	);

	assign m_axis_tdata = TDW'(drive);

endmodule
`default_nettype wire

>>> hdl/pidis_checker.sv
// Port-level checks for the PID block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pidis_checker
	import pidis_pkg::*;
#(
	parameter int ERROR_WIDTH = 24,
	localparam int TDW = ((ERROR_WIDTH + 7) / 8) * 8
) (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 cfg_we,
	input wire [CFG_IDX_W-1:0] cfg_index,
	input wire [CFG_W-1:0]     cfg_data,
	input wire                 s_axis_tvalid,
	input wire                 s_axis_tready,
	input wire                 m_axis_tvalid,
	input wire                 m_axis_tready,
	input wire [TDW-1:0]       m_axis_tdata,
	input wire                 m_axis_tuser
);

	localparam int EW = ERROR_WIDTH;

	logic [OBOUND_W-1:0] obound_q;
	logic                seen_q;
	logic [33:0]         bnd_w, bnd_neg_w;
	logic signed [EW-1:0] drv;
	logic signed [EW:0]   drv_x, bnd_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obound_q <= '0;
			seen_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_OUT_BND) obound_q <= cfg_data[OBOUND_W-1:0];
			if (s_axis_tvalid && s_axis_tready) seen_q <= 1'b1;
		end
	end

	assign bnd_w     = {{(34-OBOUND_W){1'b0}}, obound_q};
	assign bnd_neg_w = -bnd_w;
	assign drv       = m_axis_tdata[EW-1:0];
	assign drv_x     = (EW + 1)'(drv);
	assign bnd_x     = $signed(bnd_w[EW:0]);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// no output word without an input word taken first
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> seen_q)
		else $error("output word with no input accepted");

	// a clipped word sits exactly at one of the output bounds
	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		drv == bnd_w[EW-1:0] || drv == bnd_neg_w[EW-1:0])
		else $error("saturated word not at the output bound");

	// drive never leaves the output bound when the bound fits the drive width
	a_in_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (EW > OBOUND_W) |-> drv_x <= bnd_x && drv_x >= -bnd_x)
		else $error("drive outside the output bound");

endmodule

bind pid_integral_separation pidis_checker #(.ERROR_WIDTH(ERROR_WIDTH)) u_pidis_checker (.*);
`default_nettype wire
